@@ sv/ckw_pkg.sv @@
// Package: shared types, constants and helper functions of the keyword spotter.
`default_nettype none
package ckw_pkg;

    localparam int ROW_WIDTH = 16;
    localparam int COL_WIDTH = 16;
    localparam int OUT_WIDTH = 16;
    localparam int KW_COUNT  = 3;

    localparam logic [1:0] KW_WHILE = 2'd0;
    localparam logic [1:0] KW_FOR   = 2'd1;
    localparam logic [1:0] KW_IF    = 2'd2;

    localparam logic [7:0] CH_SLASH  = 8'h2F;
    localparam logic [7:0] CH_STAR   = 8'h2A;
    localparam logic [7:0] CH_QUOTE  = 8'h22;
    localparam logic [7:0] CH_BSLASH = 8'h5C;
    localparam logic [7:0] CH_UNDER  = 8'h5F;

    // keyword spelling, padded with NUL up to the 3-bit length range
    localparam logic [7:0] KW_TEXT [0:KW_COUNT-1][0:7] = '{
        '{"w", "h", "i", "l", "e", 8'h00, 8'h00, 8'h00},
        '{"f", "o", "r", 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
        '{"i", "f", 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00}
    };
    localparam logic [2:0] KW_LEN [0:KW_COUNT-1] = '{3'd5, 3'd3, 3'd2};
    localparam logic [1:0] KW_CODE [0:KW_COUNT-1] = '{KW_WHILE, KW_FOR, KW_IF};

    typedef enum logic [6:0] {
        M_NORMAL     = 7'b0000001,
        M_SLASH      = 7'b0000010,
        M_LINE_CMT   = 7'b0000100,
        M_BLOCK      = 7'b0001000,
        M_BLOCK_STAR = 7'b0010000,
        M_STRING     = 7'b0100000,
        M_ESCAPE     = 7'b1000000
    } t_mode;

    typedef struct packed {
        logic                 valid;
        logic [1:0]           kind;
        logic [ROW_WIDTH-1:0] row;
        logic [COL_WIDTH-1:0] col;
    } t_hit;

    function automatic logic is_word_char(input logic [7:0] c);
        return (c >= "A" && c <= "Z") || (c >= "a" && c <= "z") ||
               (c >= "0" && c <= "9") || (c == CH_UNDER);
    endfunction

    function automatic logic [ROW_WIDTH-1:0] row_inc(input logic [ROW_WIDTH-1:0] v);
        return (&v) ? v : v + ROW_WIDTH'(1);
    endfunction

    function automatic logic [COL_WIDTH-1:0] col_inc(input logic [COL_WIDTH-1:0] v);
        return (&v) ? v : v + COL_WIDTH'(1);
    endfunction

endpackage
`default_nettype wire

@@ sv/ckw_scan.sv @@
// Scan state: mode, word tracking, row/column counters and keyword detection.
`default_nettype none
module ckw_scan import ckw_pkg::*; (
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_step,
    input  wire logic [7:0] i_byte,
    input  wire logic       i_line_end,
    output t_hit            o_hit
);

    t_mode                r_mode, n_mode;
    logic                 r_active, n_active;
    logic [2:0]           r_len, n_len;
    logic [KW_COUNT-1:0]  r_cand, n_cand;
    logic [COL_WIDTH-1:0] r_start, n_start;
    logic [ROW_WIDTH-1:0] r_row, n_row;
    logic [COL_WIDTH-1:0] r_col, n_col;

    t_hit w_close;
    logic w_do_normal;

    // keyword match of the run as it stands now
    always_comb begin
        w_close       = '0;
        w_close.row   = r_row;
        w_close.col   = r_start;
        for (int k = KW_COUNT - 1; k >= 0; k--) begin
            if (r_active && r_cand[k] && r_len == KW_LEN[k]) begin
                w_close.valid = 1'b1;
                w_close.kind  = KW_CODE[k];
            end
        end
    end

    always_comb begin
        logic       l_fresh;
        logic [2:0] l_len;
        n_mode      = r_mode;
        n_active    = r_active;
        n_len       = r_len;
        n_cand      = r_cand;
        n_start     = r_start;
        n_row       = r_row;
        n_col       = r_col;
        o_hit       = '0;
        w_do_normal = 1'b0;
        l_fresh     = 1'b0;
        l_len       = r_len;

        if (i_line_end) begin
            o_hit    = w_close;
            n_active = 1'b0;
            n_len    = '0;
            n_cand   = '1;
            n_mode   = (r_mode == M_BLOCK || r_mode == M_BLOCK_STAR) ? M_BLOCK : M_NORMAL;
            n_row    = row_inc(r_row);
            n_col    = '0;
        end else begin
            n_col = col_inc(r_col);
            unique case (r_mode)
                M_SLASH: begin
                    if (i_byte == CH_SLASH) begin
                        n_mode = M_LINE_CMT;
                    end else if (i_byte == CH_STAR) begin
                        n_mode = M_BLOCK;
                    end else begin
                        n_mode      = M_NORMAL;
                        w_do_normal = 1'b1;
                    end
                end
                M_LINE_CMT: begin
                end
                M_BLOCK: begin
                    if (i_byte == CH_STAR) n_mode = M_BLOCK_STAR;
                end
                M_BLOCK_STAR: begin
                    if (i_byte == CH_SLASH) begin
                        n_mode = M_NORMAL;
                    end else if (i_byte != CH_STAR) begin
                        n_mode = M_BLOCK;
                    end
                end
                M_STRING: begin
                    if (i_byte == CH_QUOTE) begin
                        n_mode = M_NORMAL;
                    end else if (i_byte == CH_BSLASH) begin
                        n_mode = M_ESCAPE;
                    end
                end
                M_ESCAPE: begin
                    n_mode = M_STRING;
                end
                default: begin
                    n_mode      = M_NORMAL;
                    w_do_normal = 1'b1;
                end
            endcase

            if (w_do_normal) begin
                if (is_word_char(i_byte)) begin
                    l_fresh = !r_active;
                    l_len   = l_fresh ? 3'd0 : r_len;
                    n_cand  = l_fresh ? '1 : r_cand;
                    if (l_fresh) n_start = n_col;
                    n_active = 1'b1;
                    for (int k = 0; k < KW_COUNT; k++) begin
                        if (l_len >= KW_LEN[k] || KW_TEXT[k][l_len] != i_byte) begin
                            n_cand[k] = 1'b0;
                        end
                    end
                    n_len = (&l_len) ? l_len : l_len + 3'd1;
                end else begin
                    o_hit    = w_close;
                    n_active = 1'b0;
                    n_len    = '0;
                    n_cand   = '1;
                    if (i_byte == CH_SLASH) begin
                        n_mode = M_SLASH;
                    end else if (i_byte == CH_QUOTE) begin
                        n_mode = M_STRING;
                    end
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode   <= M_NORMAL;
            r_active <= 1'b0;
            r_len    <= '0;
            r_cand   <= '1;
            r_start  <= '0;
            r_row    <= ROW_WIDTH'(1);
            r_col    <= '0;
        end else if (i_step) begin
            r_mode   <= n_mode;
            r_active <= n_active;
            r_len    <= n_len;
            r_cand   <= n_cand;
            r_start  <= n_start;
            r_row    <= n_row;
            r_col    <= n_col;
        end
    end

endmodule
`default_nettype wire

@@ sv/c_control_keyword_spotter.sv @@
// Top level: keyword spotter with input register, scan logic and result register.
// ---------------------------------------------------------------------------
// Usage
//   Input channel (i_in_valid / o_in_ready): one item per handshake, either a
//   source character on i_text_byte or, with i_line_end high, a line end that
//   carries no character.
//   Output channel (o_out_valid / i_out_ready): one item per keyword found
//   (while, for, if) with its 1-based row and column of the first character.
//   Most input items produce no output item.
// Order: an accepted item is held in the input register and scanned when it
//   advances; a keyword it closes is presented on the outputs right after the scan.
// Throughput: one item per cycle while no result waits on i_out_ready. The
//   scan update is a single pass of small compare/increment logic between
//   the input register and the scan state / result register.
// Stall: while a result waits on i_out_ready, the input register holds one
//   more item and o_in_ready drops only once that item is also blocked. A
//   stalled result holds its payload.
// Reset (synchronous, active low): normal mode, no open word, row 1,
//   column 0, both registers empty.
// ---------------------------------------------------------------------------
`default_nettype none
module c_control_keyword_spotter import ckw_pkg::*; (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_in_valid,
    output logic                      o_in_ready,
    input  wire logic [7:0]           i_text_byte,
    input  wire logic                 i_line_end,
    output logic                      o_out_valid,
    input  wire logic                 i_out_ready,
    output logic [1:0]                o_keyword_kind,
    output logic [OUT_WIDTH-1:0]      o_found_row,
    output logic [OUT_WIDTH-1:0]      o_found_column
);

    // input register
    logic       r_in_valid;
    logic [7:0] r_in_byte;
    logic       r_in_line_end;

    // result register
    logic                 r_out_valid;
    logic [1:0]           r_kind;
    logic [ROW_WIDTH-1:0] r_row;
    logic [COL_WIDTH-1:0] r_col;

    logic w_advance;
    t_hit w_hit;

    // the held item moves on when the result register is free or draining
    assign w_advance  = r_in_valid && (!r_out_valid || i_out_ready);
    assign o_in_ready = !r_in_valid || w_advance;

    ckw_scan u_scan (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_step     (w_advance),
        .i_byte     (r_in_byte),
        .i_line_end (r_in_line_end),
        .o_hit      (w_hit)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (i_in_valid && o_in_ready) begin
            r_in_valid <= 1'b1;
        end else if (w_advance) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in_valid && o_in_ready) begin
            r_in_byte     <= i_text_byte;
            r_in_line_end <= i_line_end;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_advance && w_hit.valid) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_advance && w_hit.valid) begin
            r_kind <= w_hit.kind;
            r_row  <= w_hit.row;
            r_col  <= w_hit.col;
        end
    end

    assign o_out_valid    = r_out_valid;
    assign o_keyword_kind = r_kind;
    assign o_found_row    = OUT_WIDTH'(r_row);
    assign o_found_column = OUT_WIDTH'(r_col);

endmodule
`default_nettype wire

@@ sim/c_control_keyword_spotter_tb.sv @@
// Testbench for the keyword spotter: directed table and random C-like text.
module c_control_keyword_spotter_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import ckw_pkg::*;

    // cycles without any handshake on either channel before the run is declared hung
    localparam int STALL_LIMIT = 4000;
    // each random text phase ends once the total accepted count reaches its mark
    localparam int BURST_MARK  = 850;
    localparam int CALM_MARK   = 1150;
    localparam int TEXT_MARK   = 1636;

    typedef struct packed {
        logic [1:0]  kind;
        logic [15:0] row;
        logic [15:0] col;
    } t_found;

    // one row of the directed table; typed = expected keyword written in by hand
    typedef struct packed {
        logic [7:0] ch;
        logic       le;
        logic       typed;
        t_found     want;
    } t_step;

    localparam t_found NO_FOUND = '0;

    localparam int DIR_ROWS = 29;
    localparam t_step DIRECTED [0:DIR_ROWS-1] = '{
        // right after reset: keyword at row 1, column 1
        '{"i",   1'b0, 1'b0, NO_FOUND},
        '{"f",   1'b0, 1'b0, NO_FOUND},
        '{" ",   1'b0, 1'b1, '{KW_IF, 16'd1, 16'd1}},
        // longest keyword, closed by a line end on its own row
        '{"w",   1'b0, 1'b0, NO_FOUND},
        '{"h",   1'b0, 1'b0, NO_FOUND},
        '{"i",   1'b0, 1'b0, NO_FOUND},
        '{"l",   1'b0, 1'b0, NO_FOUND},
        '{"e",   1'b0, 1'b0, NO_FOUND},
        '{8'h00, 1'b1, 1'b1, '{KW_WHILE, 16'd1, 16'd4}},
        // run closed by a slash; slash then a letter falls back to normal text
        '{"f",   1'b0, 1'b0, NO_FOUND},
        '{"o",   1'b0, 1'b0, NO_FOUND},
        '{"r",   1'b0, 1'b0, NO_FOUND},
        '{"/",   1'b0, 1'b1, '{KW_FOR, 16'd2, 16'd1}},
        '{"i",   1'b0, 1'b0, NO_FOUND},
        '{"f",   1'b0, 1'b0, NO_FOUND},
        '{8'hFF, 1'b0, 1'b0, NO_FOUND},
        // slash right before the line end does nothing
        '{"/",   1'b0, 1'b0, NO_FOUND},
        '{8'hFF, 1'b1, 1'b0, NO_FOUND},
        // block comment opened, star just before the line end is dropped
        '{"/",   1'b0, 1'b0, NO_FOUND},
        '{"*",   1'b0, 1'b0, NO_FOUND},
        '{"*",   1'b0, 1'b0, NO_FOUND},
        '{8'h55, 1'b1, 1'b0, NO_FOUND},
        // still inside the comment on the next row, then closed
        '{"/",   1'b0, 1'b0, NO_FOUND},
        '{"*",   1'b0, 1'b0, NO_FOUND},
        '{"/",   1'b0, 1'b0, NO_FOUND},
        // string with an escaped quote
        '{8'h22, 1'b0, 1'b0, NO_FOUND},
        '{8'h5C, 1'b0, 1'b0, NO_FOUND},
        '{8'h22, 1'b0, 1'b0, NO_FOUND},
        '{8'h22, 1'b0, 1'b0, NO_FOUND}
    };

    // keyword spelling and the code each one reports
    string      kw_spell [0:2] = '{"while", "for", "if"};
    logic [1:0] kw_code  [0:2] = '{KW_WHILE, KW_FOR, KW_IF};

    logic        i_clk;
    logic        i_rst_n;
    logic        i_in_valid;
    logic        o_in_ready;
    logic [7:0]  i_text_byte;
    logic        i_line_end;
    logic        o_out_valid;
    logic        i_out_ready;
    logic [1:0]  o_keyword_kind;
    logic [15:0] o_found_row;
    logic [15:0] o_found_column;

    c_control_keyword_spotter dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in_valid     (i_in_valid),
        .o_in_ready     (o_in_ready),
        .i_text_byte    (i_text_byte),
        .i_line_end     (i_line_end),
        .o_out_valid    (o_out_valid),
        .i_out_ready    (i_out_ready),
        .o_keyword_kind (o_keyword_kind),
        .o_found_row    (o_found_row),
        .o_found_column (o_found_column)
    );

    // keywords predicted but not yet seen on the output
    t_found kw_expected [$];
    int     mismatch_count = 0;
    int     item_count     = 0;
    int     quiet_cycles   = 0;
    // calm = neither side idles
    logic   calm           = 1'b0;

    // scanner copy: mode, open run, counters
    t_mode       scan_state;
    logic        run_on;
    logic [2:0]  run_len;
    logic [2:0]  run_cand;
    logic [15:0] run_col;
    logic [15:0] row_q;
    logic [15:0] col_q;
    // keyword found by the item just scanned
    logic        hit_q;
    t_found      hit_item;

    initial begin
        i_clk = 1'b0;
    end

    always #6 i_clk = ~i_clk;

    function automatic logic word_char(input logic [7:0] c);
        return (c inside {[8'h41:8'h5A], [8'h61:8'h7A], [8'h30:8'h39]}) || c == CH_UNDER;
    endfunction

    // Ends the open run; a keyword is reported when the run is complete and
    // its letters never left that keyword's spelling.
    task automatic close_run();
        for (int k = 0; k < 3; k++) begin
            if (run_on && !hit_q && run_cand[k] && run_len == kw_spell[k].len()) begin
                hit_q    = 1'b1;
                hit_item = '{kw_code[k], row_q, run_col};
            end
        end
        run_on   = 1'b0;
        run_len  = 3'd0;
        run_cand = 3'b111;
    endtask

    // One character seen in normal mode.
    task automatic plain_char(input logic [7:0] c);
        if (word_char(c)) begin
            if (!run_on) begin
                run_on   = 1'b1;
                run_len  = 3'd0;
                run_cand = 3'b111;
                run_col  = col_q;
            end
            for (int k = 0; k < 3; k++) begin
                if (run_len >= kw_spell[k].len() || kw_spell[k][run_len] != c)
                    run_cand[k] = 1'b0;
            end
            if (run_len != 3'd7)
                run_len = run_len + 3'd1;
        end else begin
            close_run();
            if (c == CH_SLASH)
                scan_state = M_SLASH;
            else if (c == CH_QUOTE)
                scan_state = M_STRING;
        end
    endtask

    // Advances the scanner copy by one item, leaving any keyword in hit_q / hit_item.
    task automatic scan_item(input logic [7:0] c, input logic le);
        hit_q = 1'b0;
        if (le) begin
            // row reported is the one in force before the line end
            close_run();
            scan_state = (scan_state == M_BLOCK || scan_state == M_BLOCK_STAR) ? M_BLOCK : M_NORMAL;
            if (!(&row_q))
                row_q = row_q + 16'd1;
            col_q = 16'd0;
        end else begin
            if (!(&col_q))
                col_q = col_q + 16'd1;
            case (scan_state)
                M_SLASH: begin
                    if (c == CH_SLASH)
                        scan_state = M_LINE_CMT;
                    else if (c == CH_STAR)
                        scan_state = M_BLOCK;
                    else begin
                        scan_state = M_NORMAL;
                        plain_char(c);
                    end
                end
                M_LINE_CMT: ;
                M_BLOCK: begin
                    if (c == CH_STAR)
                        scan_state = M_BLOCK_STAR;
                end
                M_BLOCK_STAR: begin
                    if (c == CH_SLASH)
                        scan_state = M_NORMAL;
                    else if (c != CH_STAR)
                        scan_state = M_BLOCK;
                end
                M_STRING: begin
                    if (c == CH_QUOTE)
                        scan_state = M_NORMAL;
                    else if (c == CH_BSLASH)
                        scan_state = M_ESCAPE;
                end
                M_ESCAPE: scan_state = M_STRING;
                default: begin
                    scan_state = M_NORMAL;
                    plain_char(c);
                end
            endcase
        end
    endtask

    // Drives one item. Entered and left at a falling edge; valid stays high
    // between back-to-back items so it is never dropped and raised in one step.
    task automatic send_item(input logic [7:0] c, input logic le, input logic typed,
                             input t_found want);
        if (!calm) begin
            while ($urandom_range(0, 99) < 20) begin
                i_in_valid <= 1'b0;
                @(negedge i_clk);
            end
        end
        i_in_valid  <= 1'b1;
        i_text_byte <= c;
        i_line_end  <= le;
        do
            @(posedge i_clk);
        while (!o_in_ready);
        item_count++;
        scan_item(c, le);
        if (typed)
            kw_expected.push_back(want);
        else if (hit_q)
            kw_expected.push_back(hit_item);
        @(negedge i_clk);
    endtask

    task automatic put_char(input logic [7:0] c);
        send_item(c, 1'b0, 1'b0, NO_FOUND);
    endtask

    // line end carries a random, ignored byte
    task automatic put_eol();
        send_item(8'($urandom_range(0, 255)), 1'b1, 1'b0, NO_FOUND);
    endtask

    task automatic put_text(input string s);
        foreach (s[j])
            put_char(s[j]);
    endtask

    function automatic logic [7:0] any_word_char();
        int r;
        r = $urandom_range(0, 62);
        if (r < 26)
            return 8'(97 + r);
        else if (r < 52)
            return 8'(65 + r - 26);
        else if (r < 62)
            return 8'(48 + r - 52);
        return CH_UNDER;
    endfunction

    function automatic logic [7:0] any_sep();
        logic [7:0] c;
        do
            c = 8'($urandom_range(0, 255));
        while (word_char(c));
        return c;
    endfunction

    // One random lexical token of C-like text; mostly well formed, some noise.
    task automatic random_token();
        int    pick;
        int    n;
        string w;
        pick = $urandom_range(0, 99);
        if (pick < 25) begin
            put_text(kw_spell[$urandom_range(0, 2)]);
        end else if (pick < 35) begin
            // near misses: truncated, extended, prefixed, or a plain identifier
            w = kw_spell[$urandom_range(0, 2)];
            case ($urandom_range(0, 3))
                0: put_text(w.substr(0, w.len() - 2));
                1: begin
                    put_text(w);
                    put_char(any_word_char());
                end
                2: begin
                    put_char(any_word_char());
                    put_text(w);
                end
                default: begin
                    n = $urandom_range(1, 8);
                    repeat (n) put_char(any_word_char());
                end
            endcase
        end else if (pick < 55) begin
            case ($urandom_range(0, 4))
                0: put_char(" ");
                1: put_char("(");
                2: put_char(";");
                3: put_char(8'h09);
                default: put_char(any_sep());
            endcase
        end else if (pick < 63) begin
            put_eol();
        end else if (pick < 70) begin
            // line comment hiding keywords
            put_text("//");
            n = $urandom_range(0, 10);
            repeat (n) begin
                if ($urandom_range(0, 2) == 0)
                    put_text(kw_spell[$urandom_range(0, 2)]);
                else
                    put_char(8'($urandom_range(0, 255)));
            end
            put_eol();
        end else if (pick < 78) begin
            // block comment, may span lines and contain stray stars and slashes
            put_text("/*");
            n = $urandom_range(0, 10);
            repeat (n) begin
                case ($urandom_range(0, 4))
                    0: put_char(CH_STAR);
                    1: put_text(kw_spell[$urandom_range(0, 2)]);
                    2: put_eol();
                    3: put_char(CH_SLASH);
                    default: put_char(8'($urandom_range(0, 255)));
                endcase
            end
            put_text("*/");
        end else if (pick < 86) begin
            // string literal with escapes
            put_char(CH_QUOTE);
            n = $urandom_range(0, 8);
            repeat (n) begin
                case ($urandom_range(0, 3))
                    0: begin
                        put_char(CH_BSLASH);
                        put_char(8'($urandom_range(0, 255)));
                    end
                    1: put_text(kw_spell[$urandom_range(0, 2)]);
                    default: put_char(any_sep());
                endcase
            end
            put_char(CH_QUOTE);
        end else if (pick < 92) begin
            // division, not a comment
            put_char(CH_SLASH);
            if ($urandom_range(0, 1) == 1)
                put_text(kw_spell[$urandom_range(0, 2)]);
            else
                put_char(" ");
        end else begin
            if ($urandom_range(0, 3) == 0)
                put_eol();
            else begin
                n = $urandom_range(1, 4);
                repeat (n) put_char(8'($urandom_range(0, 255)));
            end
        end
    endtask

    // Sender holds off until every predicted keyword has come out.
    task automatic settle();
        i_in_valid <= 1'b0;
        @(negedge i_clk);
        while (kw_expected.size() != 0)
            @(negedge i_clk);
    endtask

    // Receiver: random back-pressure, none while calm.
    always @(negedge i_clk) begin
        i_out_ready <= calm || ($urandom_range(0, 99) >= 20);
    end

    // Output check against the oldest prediction.
    always @(posedge i_clk) begin : check_out
        t_found got;
        t_found want;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            got = '{o_keyword_kind, o_found_row, o_found_column};
            if (kw_expected.size() == 0) begin
                mismatch_count++;
                $display("%0t: unexpected keyword item: kind %0d row %0d column %0d",
                         $time, got.kind, got.row, got.col);
            end else begin
                want = kw_expected.pop_front();
                if (got !== want) begin
                    mismatch_count++;
                    $display("%0t: keyword item: expected kind %0d row %0d column %0d, actual kind %0d row %0d column %0d",
                             $time, want.kind, want.row, want.col, got.kind, got.row, got.col);
                end
            end
        end
    end

    // Watchdog: a long run of cycles with no handshake at all means a hang.
    always @(posedge i_clk) begin
        if ((i_in_valid && o_in_ready) || (o_out_valid && i_out_ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= STALL_LIMIT) begin
            $display("Mismatches found");
            $finish;
        end
    end

    initial begin
        i_rst_n     = 1'b0;
        i_in_valid  = 1'b0;
        i_text_byte = 8'h00;
        i_line_end  = 1'b0;
        i_out_ready = 1'b0;

        scan_state = M_NORMAL;
        run_on     = 1'b0;
        run_len    = 3'd0;
        run_cand   = 3'b111;
        run_col    = 16'd0;
        row_q      = 16'd1;
        col_q      = 16'd0;
        hit_q      = 1'b0;
        hit_item   = NO_FOUND;

        repeat (5) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // directed table
        for (int i = 0; i < DIR_ROWS; i++)
            send_item(DIRECTED[i].ch, DIRECTED[i].le, DIRECTED[i].typed, DIRECTED[i].want);
        settle();

        // random text with idling on both sides
        while (item_count < BURST_MARK)
            random_token();
        settle();

        // stretch at full rate, no idling anywhere
        calm = 1'b1;
        while (item_count < CALM_MARK)
            random_token();
        calm = 1'b0;
        while (item_count < TEXT_MARK)
            random_token();

        // leave any comment or string, then a last line with two keywords
        put_eol();
        put_char(CH_STAR);
        put_char(CH_SLASH);
        put_eol();
        put_text("while;for");
        put_eol();

        settle();
        repeat (16) @(posedge i_clk);
        if (mismatch_count == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule
